// File: rtl/core/aes128_block_cipher_core_macros.svh
// ---------------------------------------------------------------------------
// AES-128 core assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_CORE_MACROS_SVH
`define AES128_BLOCK_CIPHER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/aes_pkg.sv
// ---------------------------------------------------------------------------
// AES-128 package
// S-box tables, GF(2^8) helpers and the sequencer and key schedule state types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned RoundW    = 4;
    localparam int unsigned KeyIdxW   = 4;

    localparam logic [1:0] CfgKeyHigh = 2'd0;
    localparam logic [1:0] CfgKeyLow  = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } aes_state_t;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_RUN
    } aes_ks_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // State byte order: byte i sits in bits 127-8i .. 120-8i.
    function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

endpackage

// File: rtl/core/aes_key_sched.sv
// ---------------------------------------------------------------------------
// AES-128 key schedule
// Expands the key one round key per cycle into a round key memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_key_sched (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [127:0]                key,
    input  logic [aes_pkg::KeyIdxW-1:0] rd_idx,
    output logic [127:0]                rd_key,
    output logic                        busy
);
    import aes_pkg::*;

    aes_ks_state_t      state_reg, state_next;
    logic [RoundW-1:0]  cnt_reg, cnt_next;
    logic [127:0]       cur_reg, cur_next;
    logic [7:0]         rc_reg, rc_next;
    logic [127:0]       rk_mem [NumRounds+1];
    logic [127:0]       rd_reg;
    logic               wr_en;
    logic [RoundW-1:0]  wr_idx;
    logic [127:0]       wr_data;
    logic [127:0]       nxt_key;
    logic [31:0]        tw;
    logic [31:0]        w0, w1, w2, w3;

    always_comb begin
        tw = {sbox(cur_reg[23:16]) ^ rc_reg, sbox(cur_reg[15:8]),
              sbox(cur_reg[7:0]), sbox(cur_reg[31:24])};
        w0 = cur_reg[127:96] ^ tw;
        w1 = cur_reg[95:64] ^ w0;
        w2 = cur_reg[63:32] ^ w1;
        w3 = cur_reg[31:0] ^ w2;
        nxt_key = {w0, w1, w2, w3};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            KS_IDLE: if (start) state_next = KS_RUN;
            KS_RUN:  if (!start && cnt_reg == RoundW'(NumRounds)) state_next = KS_IDLE;
            default: state_next = KS_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        rc_next  = rc_reg;
        wr_en    = 1'b0;
        wr_idx   = cnt_reg;
        wr_data  = nxt_key;
        if (start) begin
            // Round key 0 is the key itself; expansion restarts from it.
            wr_en    = 1'b1;
            wr_idx   = '0;
            wr_data  = key;
            cur_next = key;
            cnt_next = RoundW'(1);
            rc_next  = 8'h01;
        end else if (state_reg == KS_RUN && cnt_reg <= RoundW'(NumRounds)) begin
            wr_en    = 1'b1;
            cur_next = nxt_key;
            rc_next  = xtime(rc_reg);
            cnt_next = cnt_reg + RoundW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= KS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        cur_reg <= cur_next;
        rc_reg  <= rc_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) rk_mem[wr_idx] <= wr_data;
        rd_reg <= rk_mem[rd_idx];
    end

    assign rd_key = rd_reg;
    assign busy   = start || state_reg != KS_IDLE;

endmodule

// File: rtl/core/aes_round.sv
// ---------------------------------------------------------------------------
// AES-128 round unit
// One shared forward or inverse round, reused for each round by the sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    input  logic         inverse,
    input  logic         last,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    logic [127:0] sh, sb, mx, ak;
    logic [7:0]   a0, a1, a2, a3;
    logic [7:0]   x1, x2, x4, x8;

    always_comb begin
        sh = '0;
        sb = '0;
        mx = '0;
        ak = '0;
        x1 = '0;
        x2 = '0;
        // Forward order: sub, shift, mix, add. Inverse: shift, sub, add, mix.
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inverse)
                    sh[127-8*(4*((c+r)&3)+r) -: 8] = get_b(state_in, 4*c+r);
                else
                    sh[127-8*(4*c+r) -: 8] = sbox(get_b(state_in, 4*((c+r)&3)+r));
            end
        end
        for (int i = 0; i < 16; i++)
            sb[127-8*i -: 8] = inverse ? inv_sbox(get_b(sh, i)) : get_b(sh, i);
        ak = inverse ? (sb ^ rkey) : sb;
        for (int c = 0; c < 4; c++) begin
            a0 = get_b(ak, 4*c);
            a1 = get_b(ak, 4*c+1);
            a2 = get_b(ak, 4*c+2);
            a3 = get_b(ak, 4*c+3);
            if (inverse) begin
                // Pre-step for the inverse matrix: fold 4a+... then forward mix.
                x1 = xtime(xtime(a0 ^ a2));
                x2 = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ x1;
                a1 = a1 ^ x2;
                a2 = a2 ^ x1;
                a3 = a3 ^ x2;
            end
            x4 = a0 ^ a1 ^ a2 ^ a3;
            x8 = a0;
            mx[127-8*(4*c)   -: 8] = a0 ^ x4 ^ xtime(a0 ^ a1);
            mx[127-8*(4*c+1) -: 8] = a1 ^ x4 ^ xtime(a1 ^ a2);
            mx[127-8*(4*c+2) -: 8] = a2 ^ x4 ^ xtime(a2 ^ a3);
            mx[127-8*(4*c+3) -: 8] = a3 ^ x4 ^ xtime(a3 ^ x8);
        end
        if (inverse)
            state_out = last ? ak : mx;
        else
            state_out = (last ? sb : mx) ^ rkey;
    end

endmodule

// File: rtl/core/aes128_block_cipher_core.sv
// ---------------------------------------------------------------------------
// AES-128 block cipher core
// ECB encryption and decryption with an on-chip key schedule.
// ---------------------------------------------------------------------------
// Channel   | Ports                                   | Direction
// input     | s_valid s_ready s_action s_block_*      | in
// result    | m_valid m_ready m_result_*              | out
// config    | cfg_we cfg_index cfg_data               | in
//
// After acceptance each word is added to round key 0 or 10, then run
// through the rounds of the shared round unit, each fed by the
// registered read of the round key memory.
// Words are handled one at a time and never overlap.
// After reset, and after every key write, the key schedule runs again;
// no word is accepted until it has finished.
// A result waits in the output register while m_ready is low; the core
// takes the next word only once that result has gone.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_block_cipher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import aes_pkg::*;

    aes_state_t         state_reg, state_next;
    logic [RoundW-1:0]  rnd_reg, rnd_next;
    logic               inv_reg;
    logic [127:0]       st_reg, st_next;
    logic [127:0]       in_hold_reg;
    logic [63:0]        key_high_reg, key_low_reg;
    logic               ks_start_reg;
    logic               ks_busy;
    logic [KeyIdxW-1:0] ks_rd_idx;
    logic [127:0]       rkey;
    logic [127:0]       rnd_out;
    logic               accept;
    logic               first_reg;

    // Key registers; any write restarts expansion, as does leaving reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            ks_start_reg <= 1'b1;
        end else begin
            ks_start_reg <= cfg_we;
            if (cfg_we && cfg_index == CfgKeyHigh[0:0]) key_high_reg <= cfg_data;
            if (cfg_we && cfg_index == CfgKeyLow[0:0])  key_low_reg  <= cfg_data;
        end
    end

    aes_key_sched u_ks (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ks_start_reg),
        .key     ({key_high_reg, key_low_reg}),
        .rd_idx  (ks_rd_idx),
        .rd_key  (rkey),
        .busy    (ks_busy)
    );

    aes_round u_round (
        .state_in  (st_reg),
        .rkey      (rkey),
        .inverse   (inv_reg),
        .last      (rnd_reg == RoundW'(NumRounds)),
        .state_out (rnd_out)
    );

    assign s_ready = state_reg == ST_IDLE && !ks_busy && !cfg_we;
    assign accept  = s_valid && s_ready;

    // The key index is issued ahead of its use, as the round key read is registered.
    always_comb begin
        if (state_reg == ST_IDLE)
            ks_rd_idx = s_action ? KeyIdxW'(NumRounds) : '0;
        else if (first_reg)
            ks_rd_idx = inv_reg ? KeyIdxW'(NumRounds - 1) : KeyIdxW'(1);
        else
            ks_rd_idx = inv_reg ? KeyIdxW'(NumRounds - 1) - KeyIdxW'(rnd_reg)
                                : KeyIdxW'(rnd_reg) + KeyIdxW'(1);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (!first_reg && rnd_reg == RoundW'(NumRounds)) state_next = ST_DONE;
            ST_DONE: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        rnd_next = rnd_reg;
        st_next  = st_reg;
        if (state_reg == ST_RUN) begin
            if (first_reg) begin
                st_next  = in_hold_reg ^ rkey;
                rnd_next = RoundW'(1);
            end else begin
                st_next  = rnd_out;
                rnd_next = rnd_reg + RoundW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            first_reg <= accept;
        end
        st_reg <= st_next;
        if (accept) begin
            inv_reg     <= s_action;
            in_hold_reg <= {s_block_high, s_block_low};
        end
    end

    assign m_valid       = state_reg == ST_DONE;
    assign m_result_high = st_reg[127:64];
    assign m_result_low  = st_reg[63:0];

endmodule

// File: rtl/core/aes_port_checker.sv
// ---------------------------------------------------------------------------
// AES-128 port checker
// Watches the core's ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes128_block_cipher_core_macros.svh"

module aes_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_result_high,
    input logic        cfg_we
);
    `AES_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "ready with result pending")
    `AES_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready && !m_valid, "accepted word not held off")
    `AES_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_high), "result dropped")
    `AES_ASSERT_NEXT(a_cfg_blocks, aclk, aresetn, cfg_we, !s_ready, "word taken during key expansion")
endmodule

bind aes128_block_cipher_core aes_port_checker u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_high (m_result_high),
    .cfg_we        (cfg_we)
);
